[design/eased_ramp_generator_core_assert.svh]
// assertion macros for the eased ramp generator
// used by the top level, no other dependencies
`ifndef EASED_RAMP_GENERATOR_CORE_ASSERT_SVH
`define EASED_RAMP_GENERATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ERG_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eased ramp generator: assertion failed");
// next-cycle implication
`define ERG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eased ramp generator: assertion failed");
`else
`define ERG_ASSERT_HOLD(label, clk, rst_n, ante, cons)
`define ERG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/erg_pkg.sv]
// shared widths, codes and request types of the eased ramp generator
// no dependencies
`timescale 1ns / 1ps

package erg_pkg;

  localparam int VALUE_BITS = 32;
  localparam int TIME_BITS  = 24;
  localparam int FRAC_BITS  = 16;
  localparam int DIGITS     = FRAC_BITS / 2;
  localparam int DIG_W      = $clog2(DIGITS);
  localparam int DIV_CNT_W  = $clog2(FRAC_BITS);

  localparam logic [FRAC_BITS:0]   ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+1:0] THREE_Q = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] FRAC_MAX = {FRAC_BITS{1'b1}};

  typedef enum logic [1:0] {
    ACT_JUMP    = 2'd0,
    ACT_TARGET  = 2'd1,
    ACT_ADVANCE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CRV_LINEAR   = 2'd0,
    CRV_EASE_IN  = 2'd1,
    CRV_EASE_OUT = 2'd2,
    CRV_SMOOTH   = 2'd3
  } curve_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EASE,
    ST_SCALE,
    ST_APPLY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [TIME_BITS-1:0] num;
    logic [TIME_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 start;
    logic [FRAC_BITS-1:0] frac;
    curve_t               kind;
  } ease_req_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS:0]   mag;
    logic [FRAC_BITS-1:0]  weight;
  } scale_req_t;

endpackage

[design/erg_if.sv]
// handshake channels of the eased ramp generator: input items and result items
// depends on erg_pkg
`timescale 1ns / 1ps

interface erg_in_if;
  import erg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic signed [VALUE_BITS-1:0] level;
  logic [TIME_BITS-1:0]         ramp_time;
  logic [1:0]                   curve;
  logic [TIME_BITS-1:0]         step_time;

  modport source (output valid, action, level, ramp_time, curve, step_time, input ready);
  modport sink   (input valid, action, level, ramp_time, curve, step_time, output ready);
endinterface

interface erg_out_if;
  import erg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] current_level;
  logic signed [VALUE_BITS-1:0] goal_level;
  logic                         running;
  logic                         arrived;

  modport source (output valid, current_level, goal_level, running, arrived, input ready);
  modport sink   (input valid, current_level, goal_level, running, arrived, output ready);
endinterface

[design/eased_ramp_generator_core.sv]
// top level of the eased ramp generator: item decode, ramp state and sequencing
// depends on erg_pkg, erg_if, erg_div, erg_ease, erg_scale and the assertion header
`timescale 1ns / 1ps

// Eased ramp generator. Each transfer on in_ch jumps the value, starts a ramp
// toward a new target, or advances time; every item gives exactly one result
// transfer on out_ch with the value, target, running and arrived flags after
// it. Values are signed Q16.16, the eased fraction unsigned Q0.16. Items take
// one at a time. A jump, a new target, an advance while idle or an advance that
// ends the ramp goes from the transfer to the done state and from there into
// the output register. An advance that lands inside a ramp passes in order
// through the bit-serial divider that forms elapsed over duration as a 16-bit
// quotient, the easing pipeline, the scaler that multiplies the level span two
// weight bits at a time (first forming three times the span, then 8 digits),
// the apply state and the done state, which loads the output register once it
// is free. A finished result waits in the output register while the next item
// is taken.

`include "eased_ramp_generator_core_assert.svh"

module eased_ramp_generator_core (
  input logic      clk,
  input logic      rst_n,
  erg_in_if.sink   in_ch,
  erg_out_if.source out_ch
);
  import erg_pkg::*;

  state_t                       state_r, state_nxt;

  // ramp state
  logic signed [VALUE_BITS-1:0] now_r, now_nxt;
  logic signed [VALUE_BITS-1:0] from_r, from_nxt;
  logic signed [VALUE_BITS-1:0] to_r, to_nxt;
  logic [TIME_BITS-1:0]         spent_r, spent_nxt;
  logic [TIME_BITS-1:0]         total_r, total_nxt;
  curve_t                       curve_r, curve_nxt;
  logic                         busy_r, busy_nxt;

  // span of the ramp, signed and one bit wider than a level
  logic [VALUE_BITS:0]          diff_r, diff_nxt;
  logic [VALUE_BITS:0]          mag_r;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic signed [VALUE_BITS-1:0] out_cur_r, out_cur_nxt;
  logic signed [VALUE_BITS-1:0] out_goal_r, out_goal_nxt;
  logic                         out_run_r, out_run_nxt;
  logic                         out_arr_r, out_arr_nxt;

  logic                         accept;
  logic [TIME_BITS:0]           sum;
  logic                         same_target;
  logic [VALUE_BITS:0]          applied;

  div_req_t                     div_req;
  ease_req_t                    ease_req;
  scale_req_t                   scale_req;
  logic                         div_done, ease_done, scale_done;
  logic [FRAC_BITS-1:0]         frac;
  logic [FRAC_BITS-1:0]         eased;
  logic [VALUE_BITS:0]          scaled;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign sum         = {1'b0, spent_r} + {1'b0, in_ch.step_time};
  assign same_target = (to_r == in_ch.level) && (total_r == in_ch.ramp_time)
                       && (curve_r == in_ch.curve);

  // new value: from plus or minus the truncated magnitude, so it rounds toward from
  assign applied = diff_r[VALUE_BITS] ? ({from_r[VALUE_BITS-1], from_r} - scaled)
                                      : ({from_r[VALUE_BITS-1], from_r} + scaled);

  // divider kicks off in the transfer cycle with the new elapsed time, when it stays short of the duration
  assign div_req.start = 1'b0 | (accept && (in_ch.action == ACT_ADVANCE) && busy_r
                                 && (total_r != '0) && (sum < {1'b0, total_r}));
  assign div_req.num   = sum[TIME_BITS-1:0];
  assign div_req.den   = total_r;

  assign ease_req.start = div_done;
  assign ease_req.frac  = frac;
  assign ease_req.kind  = curve_r;

  assign scale_req.start  = ease_done;
  assign scale_req.mag    = mag_r;
  assign scale_req.weight = eased;

  erg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (frac)
  );

  erg_ease u_ease (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ease_req),
    .done  (ease_done),
    .eased (eased)
  );

  erg_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scale_req),
    .done  (scale_done),
    .prod  (scaled)
  );

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    spent_nxt     = spent_r;
    total_nxt     = total_r;
    curve_nxt     = curve_r;
    busy_nxt      = busy_r;
    diff_nxt      = diff_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cur_nxt   = out_cur_r;
    out_goal_nxt  = out_goal_r;
    out_run_nxt   = out_run_r;
    out_arr_nxt   = out_arr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DONE;
          unique case (in_ch.action)
            ACT_JUMP: begin
              now_nxt   = in_ch.level;
              from_nxt  = in_ch.level;
              to_nxt    = in_ch.level;
              spent_nxt = '0;
              total_nxt = '0;
              busy_nxt  = 1'b0;
            end
            ACT_TARGET: begin
              // the same target, duration and curve again is ignored
              if (!same_target) begin
                to_nxt    = in_ch.level;
                total_nxt = in_ch.ramp_time;
                curve_nxt = curve_t'(in_ch.curve);
                from_nxt  = now_r;
                spent_nxt = '0;
                if ((in_ch.ramp_time == '0) || (now_r == in_ch.level)) begin
                  now_nxt  = in_ch.level;
                  busy_nxt = 1'b0;
                end else begin
                  busy_nxt = 1'b1;
                end
              end
            end
            ACT_ADVANCE: begin
              if (busy_r) begin
                if ((total_r == '0) || (sum >= {1'b0, total_r})) begin
                  // elapsed time saturates: snap to the target
                  spent_nxt = total_r;
                  now_nxt   = to_r;
                  busy_nxt  = 1'b0;
                end else begin
                  spent_nxt = sum[TIME_BITS-1:0];
                  diff_nxt  = {to_r[VALUE_BITS-1], to_r} - {from_r[VALUE_BITS-1], from_r};
                  state_nxt = ST_DIV;
                end
              end
            end
            default: begin
              // unknown action reports the state unchanged
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EASE;
        end
      end
      ST_EASE: begin
        if (ease_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        now_nxt   = applied[VALUE_BITS-1:0];
        busy_nxt  = (applied[VALUE_BITS-1:0] != to_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // load the output register once it is free or being emptied
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cur_nxt   = now_r;
          out_goal_nxt  = to_r;
          out_run_nxt   = busy_r;
          out_arr_nxt   = (now_r == to_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      from_r      <= '0;
      to_r        <= '0;
      spent_r     <= '0;
      total_r     <= '0;
      curve_r     <= CRV_LINEAR;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      spent_r     <= spent_nxt;
      total_r     <= total_nxt;
      curve_r     <= curve_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers; the span magnitude settles while the divider runs
  always_ff @(posedge clk) begin
    diff_r     <= diff_nxt;
    out_cur_r  <= out_cur_nxt;
    out_goal_r <= out_goal_nxt;
    out_run_r  <= out_run_nxt;
    out_arr_r  <= out_arr_nxt;
    if (state_r == ST_DIV) begin
      mag_r <= diff_r[VALUE_BITS] ? (~diff_r + 1'b1) : diff_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.current_level = out_cur_r;
  assign out_ch.goal_level    = out_goal_r;
  assign out_ch.running       = out_run_r;
  assign out_ch.arrived       = out_arr_r;

  // a ramp in progress never reports itself as arrived
  `ERG_ASSERT_HOLD(a_run_not_arrived, clk, rst_n, out_valid_r, !(out_run_r && out_arr_r))
  // while ramping, elapsed time stays short of the duration
  `ERG_ASSERT_HOLD(a_spent_below_total, clk, rst_n, busy_r, spent_r < total_r)
  // the divider only finishes while the sequencer waits for it
  `ERG_ASSERT_HOLD(a_div_in_step, clk, rst_n, div_done, state_r == ST_DIV)
  // a transfer always moves the sequencer out of idle
  `ERG_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != ST_IDLE)

endmodule

[design/erg_div.sv]
// bit-serial restoring divider: frac = (num << FRAC_BITS) / den, one bit a cycle
// depends on erg_pkg; requires num < den
`timescale 1ns / 1ps

module erg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erg_pkg::div_req_t             req,
  output logic                          done,
  output logic [erg_pkg::FRAC_BITS-1:0] quo
);
  import erg_pkg::*;

  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0] den_r;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS:0]   shifted;
  logic [TIME_BITS:0]   diff;
  logic                 fits;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, den_r};
    fits     = shifted >= {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = req.num;
      quo_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      quo_nxt = {quo_r[FRAC_BITS-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(FRAC_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[design/erg_ease.sv]
// three-stage easing pipeline: square, smoothstep weighting, select and clamp
// depends on erg_pkg
`timescale 1ns / 1ps

module erg_ease (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erg_pkg::ease_req_t            req,
  output logic                          done,
  output logic [erg_pkg::FRAC_BITS-1:0] eased
);
  import erg_pkg::*;

  logic [FRAC_BITS:0]       base;
  logic [2*FRAC_BITS+1:0]   sq_full;
  logic [2*FRAC_BITS+1:0]   sq1_r;
  logic [FRAC_BITS-1:0]     f1_r, f2_r;
  curve_t                   kind1_r, kind2_r;
  logic                     v1_r, v2_r, done_r;
  logic [FRAC_BITS:0]       sq;
  logic [FRAC_BITS+1:0]     wt;
  logic [2*FRAC_BITS+1:0]   prod2;
  logic [FRAC_BITS:0]       sq2_r;
  logic [2*FRAC_BITS+1:0]   prod2_r;
  logic [FRAC_BITS+1:0]     e_full;
  logic [FRAC_BITS-1:0]     e_r;

  // ease-out squares the complement of the fraction
  always_comb begin
    base    = (req.kind == CRV_EASE_OUT) ? (ONE_Q - {1'b0, req.frac}) : {1'b0, req.frac};
    sq_full = base * base;
  end

  always_comb begin
    sq    = sq1_r[2*FRAC_BITS:FRAC_BITS];
    wt    = THREE_Q - {1'b0, f1_r, 1'b0};
    prod2 = sq[FRAC_BITS-1:0] * wt;
  end

  always_comb begin
    case (kind2_r)
      CRV_LINEAR:   e_full = {2'b00, f2_r};
      CRV_EASE_IN:  e_full = {1'b0, sq2_r};
      CRV_EASE_OUT: e_full = {1'b0, ONE_Q - sq2_r};
      default:      e_full = prod2_r[2*FRAC_BITS+1:FRAC_BITS];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sq1_r   <= sq_full;
    f1_r    <= req.frac;
    kind1_r <= req.kind;
    sq2_r   <= sq;
    prod2_r <= prod2;
    f2_r    <= f1_r;
    kind2_r <= kind1_r;
    e_r     <= (e_full > {2'b00, FRAC_MAX}) ? FRAC_MAX : e_full[FRAC_BITS-1:0];
  end

  assign done  = done_r;
  assign eased = e_r;

endmodule

[design/erg_scale.sv]
// digit-serial scaler: (mag * weight) >> FRAC_BITS, two weight bits a cycle
// depends on erg_pkg
`timescale 1ns / 1ps

module erg_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  erg_pkg::scale_req_t          req,
  output logic                         done,
  output logic [erg_pkg::VALUE_BITS:0] prod
);
  import erg_pkg::*;

  logic [VALUE_BITS:0]   mag_r;
  logic [VALUE_BITS+2:0] mag3_r;
  logic [FRAC_BITS-1:0]  dig_r, dig_nxt;
  logic [VALUE_BITS:0]   acc_r, acc_nxt;
  logic [DIG_W-1:0]      cnt_r, cnt_nxt;
  logic                  prep_r, prep_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS+2:0] addend;
  logic [VALUE_BITS+2:0] total;

  always_comb begin
    case (dig_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, mag_r};
      2'd2:    addend = {1'b0, mag_r, 1'b0};
      default: addend = mag3_r;
    endcase
    total = {2'b00, acc_r} + addend;
  end

  // low bits shift out exactly, so the final accumulator is the truncated product
  always_comb begin
    dig_nxt  = dig_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    prep_nxt = 1'b0;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dig_nxt  = req.weight;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      prep_nxt = 1'b1;
    end else if (prep_r) begin
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = total[VALUE_BITS+2:2];
      dig_nxt = {2'b00, dig_r[FRAC_BITS-1:2]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIG_W'(DIGITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r <= 1'b0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      prep_r <= prep_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    acc_r <= acc_nxt;
    if (req.start) begin
      mag_r <= req.mag;
    end
    if (prep_r) begin
      mag3_r <= {2'b00, mag_r} + {1'b0, mag_r, 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[verif/erg_ramp_checker.sv]
// result checker for the eased ramp generator: watches both channels, predicts
// each result from its own copy of the ramp state and compares field by field
// depends on erg_pkg and the channel interfaces in erg_if
`timescale 1ns / 1ps

module erg_ramp_checker (
  input  logic clk,
  input  logic rst_n,
  erg_in_if    in_mon,
  erg_out_if   out_mon,
  output int   failures,
  output int   awaited
);
  import erg_pkg::*;

  localparam longint unsigned UNIT_Q16 = 64'd65536;

  typedef struct {
    logic signed [VALUE_BITS-1:0] current_level;
    logic signed [VALUE_BITS-1:0] goal_level;
    logic                         running;
    logic                         arrived;
  } ramp_result_t;

  // shadow copy of the ramp state
  logic signed [VALUE_BITS-1:0] now_lvl;
  logic signed [VALUE_BITS-1:0] from_lvl;
  logic signed [VALUE_BITS-1:0] to_lvl;
  logic [TIME_BITS-1:0]         spent;
  logic [TIME_BITS-1:0]         span;
  curve_t                       shape;
  logic                         busy;

  ramp_result_t ramp_expected[$];

  function automatic longint unsigned eased_weight(input longint unsigned frac,
                                                   input curve_t kind);
    longint unsigned w;
    longint unsigned inv;
    case (kind)
      CRV_EASE_IN:  w = (frac * frac) >> 16;
      CRV_EASE_OUT: begin
        inv = UNIT_Q16 - frac;
        w   = UNIT_Q16 - ((inv * inv) >> 16);
      end
      CRV_SMOOTH:   w = (((frac * frac) >> 16) * (3 * UNIT_Q16 - 2 * frac)) >> 16;
      default:      w = frac;
    endcase
    return (w > 64'd65535) ? 64'd65535 : w;
  endfunction

  task automatic advance_ramp(input logic [TIME_BITS-1:0] dt);
    longint unsigned sum;
    longint unsigned num;
    longint unsigned den;
    longint unsigned frac;
    longint unsigned mag;
    longint          diff;
    longint          moved;
    if (!busy) return;
    sum = spent;
    sum = sum + dt;
    den = span;
    if (sum < den) spent = sum[TIME_BITS-1:0];
    else spent = span;
    if (span == '0 || spent >= span) begin
      now_lvl = to_lvl;
      busy    = 1'b0;
      return;
    end
    num  = spent;
    frac = (num << 16) / den;
    diff = to_lvl;
    diff = diff - from_lvl;
    mag  = (diff < 0) ? -diff : diff;
    mag  = (mag * eased_weight(frac, shape)) >> 16;
    // span shrinks toward zero, so the step rounds toward the start level
    moved = from_lvl;
    moved = (diff < 0) ? moved - longint'(mag) : moved + longint'(mag);
    now_lvl = moved[VALUE_BITS-1:0];
    if (now_lvl == to_lvl) busy = 1'b0;
  endtask

  task automatic take_item(input logic [1:0] act,
                           input logic signed [VALUE_BITS-1:0] lvl,
                           input logic [TIME_BITS-1:0] rt,
                           input logic [1:0] cv,
                           input logic [TIME_BITS-1:0] st);
    case (act)
      ACT_JUMP: begin
        now_lvl  = lvl;
        from_lvl = lvl;
        to_lvl   = lvl;
        spent    = '0;
        span     = '0;
        busy     = 1'b0;
      end
      ACT_TARGET: begin
        if (!(to_lvl == lvl && span == rt && shape == curve_t'(cv))) begin
          to_lvl   = lvl;
          span     = rt;
          shape    = curve_t'(cv);
          from_lvl = now_lvl;
          spent    = '0;
          if (rt == '0 || now_lvl == lvl) begin
            now_lvl = lvl;
            busy    = 1'b0;
          end else begin
            busy = 1'b1;
          end
        end
      end
      ACT_ADVANCE: advance_ramp(st);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    ramp_result_t want;
    ramp_result_t seen;
    if (!rst_n) begin
      now_lvl  = '0;
      from_lvl = '0;
      to_lvl   = '0;
      spent    = '0;
      span     = '0;
      shape    = CRV_LINEAR;
      busy     = 1'b0;
      ramp_expected.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        take_item(in_mon.action, in_mon.level, in_mon.ramp_time, in_mon.curve,
                  in_mon.step_time);
        want.current_level = now_lvl;
        want.goal_level    = to_lvl;
        want.running       = busy;
        want.arrived       = (now_lvl == to_lvl);
        ramp_expected.insert(ramp_expected.size(), want);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.current_level = out_mon.current_level;
        seen.goal_level    = out_mon.goal_level;
        seen.running       = out_mon.running;
        seen.arrived       = out_mon.arrived;
        if (ramp_expected.size() == 0) begin
          $error("result transfer with nothing outstanding: current_level %0d",
                 seen.current_level);
          failures++;
        end else begin
          want = ramp_expected.pop_front();
          if (seen.current_level !== want.current_level) begin
            $error("current_level: expected %0d, got %0d", want.current_level,
                   seen.current_level);
            failures++;
          end
          if (seen.goal_level !== want.goal_level) begin
            $error("goal_level: expected %0d, got %0d", want.goal_level,
                   seen.goal_level);
            failures++;
          end
          if (seen.running !== want.running) begin
            $error("running: expected %0b, got %0b", want.running, seen.running);
            failures++;
          end
          if (seen.arrived !== want.arrived) begin
            $error("arrived: expected %0b, got %0b", want.arrived, seen.arrived);
            failures++;
          end
        end
      end
    end
    awaited <= ramp_expected.size();
  end

endmodule

[verif/eased_ramp_generator_core_test.sv]
// testbench top for the eased ramp generator: clock, reset, item stimulus,
// result back-pressure and the final verdict
// depends on erg_pkg, erg_if, the core and erg_ramp_checker
`timescale 1ns / 1ps

module eased_ramp_generator_core_test;
  import erg_pkg::*;

  // action code the block has no meaning for, it must only report its state
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ROUNDS = 4;
  localparam int ROUND_ITEMS   = 230;
  // result counts at which the receiver backs off for a long stretch
  localparam int HOLD_AT_FIRST  = 150;
  localparam int HOLD_AT_SECOND = 620;
  localparam int HOLD_CYCLES    = 400;
  // comfortably beyond the slowest advance inside a ramp
  localparam int SETTLE_CYCLES  = 48;

  localparam logic signed [VALUE_BITS-1:0] LEVEL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] LEVEL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [TIME_BITS-1:0]         TIME_MAX  = {TIME_BITS{1'b1}};

  logic clk;
  logic rst_n;
  int   failures;
  int   awaited;
  int   cycles;
  bit   brisk;

  // what the stimulus last asked for, so sequences can build on it
  logic signed [VALUE_BITS-1:0] goal_lvl;
  logic [TIME_BITS-1:0]         goal_time;
  logic [1:0]                   goal_curve;
  logic signed [VALUE_BITS-1:0] jump_lvl;

  erg_in_if  in_ch ();
  erg_out_if out_ch ();

  eased_ramp_generator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  erg_ramp_checker checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .failures (failures),
    .awaited  (awaited)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls per transfer, calm stretches with ready held
  // high, and two long hold-offs so the core backs up and stalls its input
  initial begin : receiver
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 19);
      if (taken == HOLD_AT_FIRST || taken == HOLD_AT_SECOND) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // one item transfer; valid stays high afterwards unless the next item waits
  task automatic offer(input logic [1:0] act,
                       input logic signed [VALUE_BITS-1:0] lvl,
                       input logic [TIME_BITS-1:0] rt,
                       input logic [1:0] cv,
                       input logic [TIME_BITS-1:0] st);
    int gap;
    if ($urandom_range(0, 29) == 0) brisk = !brisk;
    gap = brisk ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.action    <= act;
    in_ch.level     <= lvl;
    in_ch.ramp_time <= rt;
    in_ch.curve     <= cv;
    in_ch.step_time <= st;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sender pause: stop offering and let every outstanding result come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] pick_level();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0: v = LEVEL_MAX;
      1: v = LEVEL_MIN;
      2: v = VALUE_BITS'($urandom_range(0, 2) - 1);
      3, 4: begin
        // a few whole units either side of zero
        v = VALUE_BITS'($urandom_range(0, 32'h000F_FFFF));
        if ($urandom_range(0, 1)) v = -v;
      end
      5: v = VALUE_BITS'(goal_lvl + $urandom_range(0, 255) - 128);
      default: v = VALUE_BITS'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_ramp();
    logic [TIME_BITS-1:0] t;
    case ($urandom_range(0, 9))
      0: t = '0;
      1: t = TIME_MAX;
      2: t = TIME_BITS'(1);
      3, 4, 5: t = TIME_BITS'($urandom_range(1, 32));
      6, 7: t = TIME_BITS'($urandom_range(33, 4096));
      default: t = TIME_BITS'($urandom());
    endcase
    return t;
  endfunction

  // mostly small slices of the running ramp so advances land inside it
  function automatic logic [TIME_BITS-1:0] pick_step();
    logic [TIME_BITS-1:0] t;
    int slice;
    slice = goal_time / 6 + 1;
    case ($urandom_range(0, 9))
      0: t = '0;
      1: t = TIME_BITS'($urandom());
      2: t = TIME_MAX;
      3: t = goal_time;
      default: t = TIME_BITS'($urandom_range(1, slice));
    endcase
    return t;
  endfunction

  task automatic new_goal(input logic signed [VALUE_BITS-1:0] lvl,
                          input logic [TIME_BITS-1:0] rt, input logic [1:0] cv);
    goal_lvl   = lvl;
    goal_time  = rt;
    goal_curve = cv;
    offer(ACT_TARGET, lvl, rt, cv, TIME_BITS'($urandom()));
  endtask

  task automatic random_round(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        new_goal(pick_level(), pick_ramp(), 2'($urandom_range(0, 3)));
      end else if (pick < 18) begin
        // same target, duration and easing again
        offer(ACT_TARGET, goal_lvl, goal_time, goal_curve, TIME_BITS'($urandom()));
      end else if (pick < 21) begin
        // near repeat: only the easing changes
        new_goal(goal_lvl, goal_time, 2'(goal_curve + $urandom_range(1, 3)));
      end else if (pick < 27) begin
        jump_lvl = pick_level();
        offer(ACT_JUMP, jump_lvl, TIME_BITS'($urandom()), 2'($urandom_range(0, 3)),
              TIME_BITS'($urandom()));
      end else if (pick < 29) begin
        // target equal to where the value last jumped to
        new_goal(jump_lvl, pick_ramp(), 2'($urandom_range(0, 3)));
      end else if (pick < 31) begin
        offer(ACT_UNUSED, VALUE_BITS'($urandom()), TIME_BITS'($urandom()),
              2'($urandom_range(0, 3)), TIME_BITS'($urandom()));
      end else begin
        offer(ACT_ADVANCE, VALUE_BITS'($urandom()), TIME_BITS'($urandom()),
              2'($urandom_range(0, 3)), pick_step());
      end
    end
  endtask

  initial begin : stimulus
    brisk      = 1'b0;
    goal_lvl   = '0;
    goal_time  = '0;
    goal_curve = CRV_LINEAR;
    jump_lvl   = '0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_JUMP;
    in_ch.level     <= '0;
    in_ch.ramp_time <= '0;
    in_ch.curve     <= CRV_LINEAR;
    in_ch.step_time <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle advance and unknown action straight out of reset
    offer(ACT_ADVANCE, LEVEL_MAX, TIME_MAX, CRV_SMOOTH, TIME_MAX);
    offer(ACT_UNUSED, LEVEL_MIN, TIME_MAX, CRV_SMOOTH, TIME_MAX);
    // jumps to both extremes, then the widest span over the longest ramp
    offer(ACT_JUMP, LEVEL_MAX, '0, CRV_LINEAR, '0);
    offer(ACT_JUMP, LEVEL_MIN, '0, CRV_LINEAR, '0);
    offer(ACT_TARGET, LEVEL_MAX, TIME_MAX, CRV_LINEAR, '0);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, '0);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, 1);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, 24'h80_0000);
    // repeated target is ignored, then elapsed time saturates and snaps
    offer(ACT_TARGET, LEVEL_MAX, TIME_MAX, CRV_LINEAR, '0);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, TIME_MAX);
    // target already reached, then a zero duration ramp
    offer(ACT_TARGET, LEVEL_MAX, 100, CRV_LINEAR, '0);
    offer(ACT_JUMP, '0, '0, CRV_LINEAR, '0);
    offer(ACT_TARGET, 32'sh0001_0000, '0, CRV_EASE_IN, '0);
    // short ease-in ramp downwards, then the easing alone changes mid-ramp
    offer(ACT_TARGET, 32'shFFFB_0000, 10, CRV_EASE_IN, '0);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, 3);
    offer(ACT_TARGET, 32'shFFFB_0000, 10, CRV_SMOOTH, '0);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, 4);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, TIME_MAX);
    // fraction one step short of the end, where the easing clamps
    offer(ACT_TARGET, LEVEL_MIN, TIME_MAX, CRV_EASE_OUT, '0);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, TIME_MAX - 1'b1);
    offer(ACT_TARGET, LEVEL_MAX, TIME_MAX, CRV_SMOOTH, '0);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, TIME_MAX - 1'b1);
    // unknown action and a jump while a ramp is running
    offer(ACT_UNUSED, '0, '0, CRV_LINEAR, 7);
    offer(ACT_JUMP, -1, TIME_MAX, CRV_SMOOTH, TIME_MAX);
    offer(ACT_ADVANCE, '0, '0, CRV_LINEAR, 5);
    wait_for_results();

    // random sequences, draining between rounds
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      random_round(ROUND_ITEMS);
      wait_for_results();
    end

    // make sure nothing stray follows the last result
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && awaited == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
